// File: hw/rtl/four_point_square_test_assert.svh
// Assertion macros of the square test checker.
`ifndef FOUR_POINT_SQUARE_TEST_ASSERT_SVH
`define FOUR_POINT_SQUARE_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("square test check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("square test check failed");

// Next-cycle implication that is also checked across reset.
`define SQT_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("square test check failed");

`endif

// File: hw/rtl/sqt_pkg.sv
// Shared types and constants of the four point square test.
package sqt_pkg;

    localparam int NUM_PTS   = 4;
    localparam int NUM_PAIRS = 6;

    // Tolerance register
    localparam int          TOL_W     = 6;
    localparam logic [5:0]  TOL_RESET = 6'd10;

    // Percent scale of the closeness tests
    localparam int          PCT_W    = 8;
    localparam logic [7:0]  PCT_BASE = 8'd100;

    typedef logic [1:0] t_pt_idx;

    // Point pairs in the order (1,2) (1,3) (1,4) (2,3) (2,4) (3,4)
    localparam t_pt_idx PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam t_pt_idx PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    // Advance strobes for a two-stage sub-block
    typedef struct packed {
        logic first;
        logic second;
    } t_adv_pair;

endpackage

// File: hw/rtl/sqt_dist_lane.sv
// One distance lane: squared distance between two points, two stages.
module sqt_dist_lane
    import sqt_pkg::*;
#(
    parameter int W = 16
) (
    input  logic           i_clk,
    input  t_adv_pair      i_adv,
    input  logic [W-1:0]   i_ax,
    input  logic [W-1:0]   i_ay,
    input  logic [W-1:0]   i_bx,
    input  logic [W-1:0]   i_by,
    output logic [2*W:0]   o_dist
);

    logic signed [W:0]       w_dx;
    logic signed [W:0]       w_dy;
    logic signed [2*W+1:0]   w_sqx;
    logic signed [2*W+1:0]   w_sqy;
    logic [2*W-1:0]          r_sq_x;
    logic [2*W-1:0]          r_sq_y;
    logic [2*W:0]            r_dist;

    // Differences and squares; |d| < 2^W so the square fits in 2W bits
    assign w_dx  = $signed({i_ax[W-1], i_ax}) - $signed({i_bx[W-1], i_bx});
    assign w_dy  = $signed({i_ay[W-1], i_ay}) - $signed({i_by[W-1], i_by});
    assign w_sqx = (2*W+2)'(w_dx) * (2*W+2)'(w_dx);
    assign w_sqy = (2*W+2)'(w_dy) * (2*W+2)'(w_dy);

    always_ff @(posedge i_clk) begin
        if (i_adv.first) begin
            r_sq_x <= w_sqx[2*W-1:0];
            r_sq_y <= w_sqy[2*W-1:0];
        end
    end

    // Sum of the two squares
    always_ff @(posedge i_clk) begin
        if (i_adv.second) begin
            r_dist <= {1'b0, r_sq_x} + {1'b0, r_sq_y};
        end
    end

    assign o_dist = r_dist;

endmodule

// File: hw/rtl/sqt_minmax.sv
// Merge of the six distances into side (min) and diagonal (max), two stages.
module sqt_minmax
    import sqt_pkg::*;
#(
    parameter int DW = 33
) (
    input  logic           i_clk,
    input  t_adv_pair      i_adv,
    input  logic [DW-1:0]  i_dist [NUM_PAIRS],
    output logic [DW-1:0]  o_dist [NUM_PAIRS],
    output logic [DW-1:0]  o_side,
    output logic [DW-1:0]  o_diag
);

    localparam int NUM_GRP = NUM_PAIRS / 2;

    logic [DW-1:0] r_mn     [NUM_GRP];
    logic [DW-1:0] r_mx     [NUM_GRP];
    logic [DW-1:0] r_dist_a [NUM_PAIRS];
    logic [DW-1:0] r_dist_b [NUM_PAIRS];
    logic [DW-1:0] r_side;
    logic [DW-1:0] r_diag;
    logic [DW-1:0] w_side;
    logic [DW-1:0] w_diag;
    logic          w_lt01, w_lt02, w_lt12;
    logic          w_gt01, w_gt02, w_gt12;

    // First level: min and max of each neighbor pair
    always_ff @(posedge i_clk) begin
        if (i_adv.first) begin
            for (int g = 0; g < NUM_GRP; g++) begin
                if (i_dist[2*g] < i_dist[2*g+1]) begin
                    r_mn[g] <= i_dist[2*g];
                    r_mx[g] <= i_dist[2*g+1];
                end else begin
                    r_mn[g] <= i_dist[2*g+1];
                    r_mx[g] <= i_dist[2*g];
                end
            end
            r_dist_a <= i_dist;
        end
    end

    // Second level: three-way select from parallel compares
    assign w_lt01 = r_mn[0] < r_mn[1];
    assign w_lt02 = r_mn[0] < r_mn[2];
    assign w_lt12 = r_mn[1] < r_mn[2];
    assign w_gt01 = r_mx[0] > r_mx[1];
    assign w_gt02 = r_mx[0] > r_mx[2];
    assign w_gt12 = r_mx[1] > r_mx[2];

    always_comb begin
        priority if (w_lt01 && w_lt02) begin
            w_side = r_mn[0];
        end else if (w_lt12) begin
            w_side = r_mn[1];
        end else begin
            w_side = r_mn[2];
        end
        priority if (w_gt01 && w_gt02) begin
            w_diag = r_mx[0];
        end else if (w_gt12) begin
            w_diag = r_mx[1];
        end else begin
            w_diag = r_mx[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.second) begin
            r_side   <= w_side;
            r_diag   <= w_diag;
            r_dist_b <= r_dist_a;
        end
    end

    assign o_dist = r_dist_b;
    assign o_side = r_side;
    assign o_diag = r_diag;

endmodule

// File: hw/rtl/sqt_close_lane.sv
// One closeness lane: scales a distance and tests it against side and diagonal bounds.
module sqt_close_lane
    import sqt_pkg::*;
#(
    parameter int DW = 33,
    parameter int PW = 42
) (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic [DW-1:0]  i_dist,
    input  logic [PW-1:0]  i_side_lo,
    input  logic [PW-1:0]  i_side_hi,
    input  logic [PW-1:0]  i_diag_lo,
    input  logic [PW-1:0]  i_diag_hi,
    output logic           o_near_side,
    output logic           o_near_diag
);

    logic [PW-1:0] r_lhs;

    // 100 * dist
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lhs <= PW'(i_dist) * PW'(PCT_BASE);
        end
    end

    assign o_near_side = (r_lhs >= i_side_lo) && (r_lhs <= i_side_hi);
    assign o_near_diag = (r_lhs >= i_diag_lo) && (r_lhs <= i_diag_hi);

endmodule

// File: hw/rtl/four_point_square_test.sv
// Top level of the four point square test: distance lanes, min/max merge, closeness lanes.
//
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_p1_x .. i_p4_y
//  out     | output    | o_out_valid / i_out_ready   | o_square_found
//  cfg     | input     | i_cfg_wr_en (no wait)       | i_cfg_wr_data (tolerance %)
//
//  Six-stage pipeline: one word per cycle sustained while the output is taken.
//  Stages: squares, sums, pair min/max, side/diag, scaled products, verdict register.
//  Each stage advances when it is empty or its successor advances, so bubbles
//  close up and input is taken while a result waits at the output if a stage is empty.
//  Synchronous active-low reset empties the pipeline and sets the tolerance to 10.
module four_point_square_test
    import sqt_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [TOL_W-1:0]        i_cfg_wr_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [COORD_WIDTH-1:0]  i_p1_x,
    input  logic [COORD_WIDTH-1:0]  i_p1_y,
    input  logic [COORD_WIDTH-1:0]  i_p2_x,
    input  logic [COORD_WIDTH-1:0]  i_p2_y,
    input  logic [COORD_WIDTH-1:0]  i_p3_x,
    input  logic [COORD_WIDTH-1:0]  i_p3_y,
    input  logic [COORD_WIDTH-1:0]  i_p4_x,
    input  logic [COORD_WIDTH-1:0]  i_p4_y,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_square_found
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = 2*W + 1;
    localparam int PW   = DW + 9;
    localparam int NSTG = 6;
    localparam int CW   = 3;

    logic [W-1:0]        w_px [NUM_PTS];
    logic [W-1:0]        w_py [NUM_PTS];
    logic [NSTG:1]       r_vld;
    logic [NSTG:1]       w_adv;
    logic [TOL_W-1:0]    r_tol;
    logic [PCT_W-1:0]    w_f_lo;
    logic [PCT_W-1:0]    w_f_hi;
    logic [DW-1:0]       w_dist   [NUM_PAIRS];
    logic [DW-1:0]       w_dist_m [NUM_PAIRS];
    logic [DW-1:0]       w_side;
    logic [DW-1:0]       w_diag;
    logic [PW-1:0]       r_side_lo;
    logic [PW-1:0]       r_side_hi;
    logic [PW-1:0]       r_diag_lo;
    logic [PW-1:0]       r_diag_hi;
    logic [PW-1:0]       r_diag_lhs;
    logic [NUM_PAIRS-1:0] w_near_side;
    logic [NUM_PAIRS-1:0] w_near_diag;
    logic [CW-1:0]       w_cnt_side;
    logic [CW-1:0]       w_cnt_diag;
    logic                w_diag_ok;
    logic                n_found;
    logic                r_found;
    t_adv_pair           w_adv_lane;
    t_adv_pair           w_adv_mm;

    assign w_px[0] = i_p1_x;  assign w_py[0] = i_p1_y;
    assign w_px[1] = i_p2_x;  assign w_py[1] = i_p2_y;
    assign w_px[2] = i_p3_x;  assign w_py[2] = i_p3_y;
    assign w_px[3] = i_p4_x;  assign w_py[3] = i_p4_y;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Per-stage advance: a stage moves when empty or when its successor moves
    always_comb begin
        w_adv[NSTG] = !r_vld[NSTG] || i_out_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_adv[1];
    assign o_out_valid = r_vld[NSTG];

    // Distance lanes, one per point pair
    assign w_adv_lane = '{first: w_adv[1], second: w_adv[2]};

    for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_dist
        sqt_dist_lane #(.W(W)) u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv_lane),
            .i_ax   (w_px[PAIR_A[g]]),
            .i_ay   (w_py[PAIR_A[g]]),
            .i_bx   (w_px[PAIR_B[g]]),
            .i_by   (w_py[PAIR_B[g]]),
            .o_dist (w_dist[g])
        );
    end

    // Side and diagonal
    assign w_adv_mm = '{first: w_adv[3], second: w_adv[4]};

    sqt_minmax #(.DW(DW)) u_minmax (
        .i_clk  (i_clk),
        .i_adv  (w_adv_mm),
        .i_dist (w_dist),
        .o_dist (w_dist_m),
        .o_side (w_side),
        .o_diag (w_diag)
    );

    // Reference bounds: (100 -/+ t) times side and diagonal
    assign w_f_lo = PCT_BASE - PCT_W'(r_tol);
    assign w_f_hi = PCT_BASE + PCT_W'(r_tol);

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_side_lo  <= PW'(w_side) * PW'(w_f_lo);
            r_side_hi  <= PW'(w_side) * PW'(w_f_hi);
            r_diag_lo  <= PW'(w_diag) * PW'(w_f_lo);
            r_diag_hi  <= PW'(w_diag) * PW'(w_f_hi);
            r_diag_lhs <= PW'(w_diag) * PW'(PCT_BASE);
        end
    end

    // Closeness lanes
    for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_close
        sqt_close_lane #(.DW(DW), .PW(PW)) u_close (
            .i_clk       (i_clk),
            .i_adv       (w_adv[5]),
            .i_dist      (w_dist_m[g]),
            .i_side_lo   (r_side_lo),
            .i_side_hi   (r_side_hi),
            .i_diag_lo   (r_diag_lo),
            .i_diag_hi   (r_diag_hi),
            .o_near_side (w_near_side[g]),
            .o_near_diag (w_near_diag[g])
        );
    end

    // Diagonal against twice the side; bounds of 2*side are the side bounds doubled
    assign w_diag_ok = (r_diag_lhs >= {r_side_lo[PW-2:0], 1'b0})
                    && (r_diag_lhs <= {r_side_hi[PW-2:0], 1'b0});

    // Merge: count lanes and form the verdict
    always_comb begin
        w_cnt_side = '0;
        w_cnt_diag = '0;
        for (int g = 0; g < NUM_PAIRS; g++) begin
            w_cnt_side = w_cnt_side + CW'(w_near_side[g]);
            w_cnt_diag = w_cnt_diag + CW'(w_near_diag[g]);
        end
        n_found = w_diag_ok && (w_cnt_side == CW'(4)) && (w_cnt_diag == CW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_found <= n_found;
        end
    end

    assign o_square_found = r_found;

endmodule

// File: hw/rtl/sqt_checker.sv
// Port-level checker for the four point square test and its bind.
`include "four_point_square_test_assert.svh"

module sqt_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic o_in_ready,
    input  logic o_out_valid,
    input  logic i_out_ready,
    input  logic o_square_found
);

    // A result not taken stays offered
    `SQT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A result not taken keeps its value
    `SQT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_square_found))

    // Reset empties the pipeline
    `SQT_ASSERT_ALWAYS_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

    // An empty output slot lets the whole pipeline move
    `SQT_ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // A taken result frees the last stage, so input is taken too
    `SQT_ASSERT_IMPL(a_take_ready, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready)

endmodule

bind four_point_square_test sqt_checker u_sqt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_square_found (o_square_found)
);

// File: sim/tb.sv
// Self-checking testbench for the four point square test: predicts each verdict and compares.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sqt_pkg::*;

    localparam int COORD_W        = 16;
    localparam int PHASES         = 6;
    localparam int N_DIRECTED     = 16;
    localparam int RANDOM_PER_PH  = 240;
    localparam int DRAIN_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic signed [COORD_W-1:0] t_coord;
    // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y
    typedef t_coord t_quad [8];

    // Expected verdicts, tolerance copy and the verdict predictor
    class square_board;
        bit               verdict_q[$];
        logic [TOL_W-1:0] tolerance;
        int               errors;

        function new();
            tolerance = TOL_RESET;
            errors    = 0;
        endfunction

        // a lies within +/- tolerance percent of b
        function bit near(logic [63:0] a, logic [63:0] b);
            logic [63:0] lhs;
            logic [63:0] lo_lim;
            logic [63:0] hi_lim;
            lhs    = 64'(PCT_BASE) * a;
            lo_lim = (64'(PCT_BASE) - 64'(tolerance)) * b;
            hi_lim = (64'(PCT_BASE) + 64'(tolerance)) * b;
            return (lhs >= lo_lim) && (lhs <= hi_lim);
        endfunction

        function bit square_verdict(t_quad q);
            longint      px[4];
            longint      py[4];
            longint      dx;
            longint      dy;
            logic [63:0] d2[6];
            logic [63:0] side;
            logic [63:0] diag;
            int          n;
            int          near_side;
            int          near_diag;
            n         = 0;
            near_side = 0;
            near_diag = 0;
            for (int i = 0; i < 4; i++) begin
                px[i] = q[2*i];
                py[i] = q[2*i+1];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = i + 1; j < 4; j++) begin
                    dx    = px[i] - px[j];
                    dy    = py[i] - py[j];
                    d2[n] = 64'(dx * dx) + 64'(dy * dy);
                    n++;
                end
            end
            side = d2[0];
            diag = d2[0];
            for (int i = 1; i < 6; i++) begin
                if (d2[i] < side) side = d2[i];
                if (d2[i] > diag) diag = d2[i];
            end
            if (!near(diag, 2 * side)) return 1'b0;
            for (int i = 0; i < 6; i++) begin
                if (near(d2[i], side)) near_side++;
                if (near(d2[i], diag)) near_diag++;
            end
            return (near_side == 4) && (near_diag == 2);
        endfunction

        function void note_input(t_quad q);
            verdict_q = {verdict_q, square_verdict(q)};
        endfunction

        function void check_result(logic got);
            bit want;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result word: square_found %0b", got);
                return;
            end
            want = verdict_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("square_found expected %0b got %0b", want, got);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [TOL_W-1:0]   i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [COORD_W-1:0] i_p1_x, i_p1_y, i_p2_x, i_p2_y;
    logic [COORD_W-1:0] i_p3_x, i_p3_y, i_p4_x, i_p4_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_square_found;

    square_board board;
    bit          calm;
    int          stall_left;
    int          cycle_cnt;

    four_point_square_test #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_p1_x         (i_p1_x),
        .i_p1_y         (i_p1_y),
        .i_p2_x         (i_p2_x),
        .i_p2_y         (i_p2_y),
        .i_p3_x         (i_p3_x),
        .i_p3_y         (i_p3_y),
        .i_p4_x         (i_p4_x),
        .i_p4_y         (i_p4_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_square_found (o_square_found)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= gap_len();
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_square_found);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("four_point_square_test: mismatch");
            $finish;
        end
    end

    function automatic t_quad pts(int x1, int y1, int x2, int y2,
                                  int x3, int y3, int x4, int y4);
        t_quad q;
        q[0] = x1[COORD_W-1:0]; q[1] = y1[COORD_W-1:0];
        q[2] = x2[COORD_W-1:0]; q[3] = y2[COORD_W-1:0];
        q[4] = x3[COORD_W-1:0]; q[5] = y3[COORD_W-1:0];
        q[6] = x4[COORD_W-1:0]; q[7] = y4[COORD_W-1:0];
        return q;
    endfunction

    // Hand-picked shapes and field extremes
    function automatic t_quad directed_quad(int k);
        case (k)
            0:  return pts(0, 0, 4, 0, 4, 4, 0, 4);                     // axis square
            1:  return pts(0, 0, 4, 4, 4, 0, 0, 4);                     // diagonal order
            2:  return pts(0, 0, 3, 4, -1, 7, -4, 3);                   // tilted square
            3:  return pts(0, 0, 0, 0, 0, 0, 0, 0);                     // all coincident
            4:  return pts(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
            5:  return pts(5, 5, 5, 5, 5, 5, 9, 9);                     // three coincident
            6:  return pts(0, 0, 0, 0, 5, 5, 5, 5);                     // two coincident pairs
            7:  return pts(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
            8:  return pts(0, 0, 4, 0, 4, 5, 0, 5);                     // rectangle
            9:  return pts(0, 0, 10, 0, 10, 11, 0, 11);                 // near-square rectangle
            10: return pts(0, 0, 10, 0, 15, 8, 5, 8);                   // parallelogram
            11: return pts(0, 0, 100, 0, 100, 103, 0, 100);             // slightly off square
            12: return pts(0, 0, 1, 0, 2, 0, 3, 0);                     // collinear
            13: return pts(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767);
            14: return pts(21845, -21846, -21846, 21845, 21845, -21846, -21846, 21845);
            default: return pts(-1, -1, 0, -1, 0, 0, -1, 0);            // unit square at -1
        endcase
    endfunction

    // Rectangle on side vector (a,b); ratio16 = 16 gives a square
    function automatic t_quad shape_quad(int span, int jitter_pct, int ratio16);
        int    a, b, vx, vy, cx, cy, lim, jit, t;
        int    px[4];
        int    py[4];
        t_quad q;
        a   = int'($urandom_range(0, 2 * span)) - span;
        b   = int'($urandom_range(0, 2 * span)) - span;
        vx  = -b * ratio16 / 16;
        vy  = a * ratio16 / 16;
        jit = ((a < 0 ? -a : a) + (b < 0 ? -b : b)) * jitter_pct / 100;
        lim = 16383 - 2 * span - jit;
        if (lim < 0) lim = 0;
        cx = int'($urandom_range(0, 2 * lim)) - lim;
        cy = int'($urandom_range(0, 2 * lim)) - lim;
        px[0] = cx;           py[0] = cy;
        px[1] = cx + a;       py[1] = cy + b;
        px[2] = cx + a + vx;  py[2] = cy + b + vy;
        px[3] = cx + vx;      py[3] = cy + vy;
        for (int k = 0; k < 4; k++) begin
            px[k] += int'($urandom_range(0, 2 * jit)) - jit;
            py[k] += int'($urandom_range(0, 2 * jit)) - jit;
        end
        // shuffle point order
        for (int k = 3; k > 0; k--) begin
            t = $urandom_range(0, k);
            {px[k], px[t]} = {px[t], px[k]};
            {py[k], py[t]} = {py[t], py[k]};
        end
        for (int k = 0; k < 4; k++) begin
            q[2*k]   = px[k][COORD_W-1:0];
            q[2*k+1] = py[k][COORD_W-1:0];
        end
        return q;
    endfunction

    function automatic t_quad random_quad();
        int    r, span, jpct;
        t_quad q;
        r    = $urandom_range(0, 99);
        span = $urandom_range(1, 1 << $urandom_range(1, 13));
        jpct = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 8);
        if (r < 45) begin
            q = shape_quad(span, jpct, 16);
        end else if (r < 60) begin
            q = shape_quad(span, jpct / 2, $urandom_range(12, 20));
        end else if (r < 70) begin
            // coincident points
            q = shape_quad(span, 0, 16);
            case ($urandom_range(0, 3))
                0: begin
                    for (int k = 1; k < 4; k++) begin
                        q[2*k] = q[0];
                        q[2*k+1] = q[1];
                    end
                end
                1: begin q[2] = q[0]; q[3] = q[1]; end
                2: begin q[2] = q[0]; q[3] = q[1]; q[6] = q[4]; q[7] = q[5]; end
                default: begin q[2] = q[0]; q[3] = q[1]; q[4] = q[0]; q[5] = q[1]; end
            endcase
        end else if (r < 80) begin
            // large squares, coordinates may wrap
            q = shape_quad($urandom_range(8192, 32767), jpct, 16);
        end else begin
            for (int k = 0; k < 8; k++) q[k] = t_coord'($urandom_range(0, 65535));
        end
        return q;
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(t_quad q);
        int gap;
        i_in_valid <= 1'b1;
        i_p1_x <= q[0]; i_p1_y <= q[1];
        i_p2_x <= q[2]; i_p2_y <= q[3];
        i_p3_x <= q[4]; i_p3_y <= q[5];
        i_p4_x <= q[6]; i_p4_y <= q[7];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_input(q);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        board.tolerance = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [TOL_W-1:0] phase_tolerance(int ph);
        case (ph)
            1:       return '0;
            2:       return '1;
            3:       return TOL_W'(49);
            4:       return TOL_W'($urandom_range(0, 63));
            default: return TOL_RESET;
        endcase
    endfunction

    // Main sequence
    initial begin
        board         = new();
        calm          = 1'b0;
        stall_left    = 0;
        cycle_cnt     = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_out_ready   <= 1'b0;
        i_p1_x <= '0; i_p1_y <= '0; i_p2_x <= '0; i_p2_y <= '0;
        i_p3_x <= '0; i_p3_y <= '0; i_p4_x <= '0; i_p4_y <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first phase runs on the reset tolerance
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                write_tolerance(phase_tolerance(ph));
            end
            for (int k = 0; k < N_DIRECTED; k++) send_word(directed_quad(k));
            for (int n = 0; n < RANDOM_PER_PH; n++) begin
                if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
                send_word(random_quad());
            end
            i_in_valid <= 1'b0;
            calm = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("four_point_square_test: match");
        end else begin
            $display("four_point_square_test: mismatch");
        end
        $finish;
    end

endmodule
